// ===== sv/rdmc_pkg.sv =====
package rdmc_pkg;

  // Field widths fixed by the item formats.
  localparam int COORD_W = 7;
  localparam int RAND_W  = 8;
  localparam int SIZE_W  = 7;
  localparam int COUNT_W = 11;

  // Result action codes.
  localparam logic [1:0] ACT_CARVE   = 2'd0;
  localparam logic [1:0] ACT_BACK    = 2'd1;
  localparam logic [1:0] ACT_IGNORE  = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  // Item function codes.
  localparam logic FUNC_STEP    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  // Neighbour directions, in the order they are examined.
  localparam logic [1:0] DIR_POS_COL = 2'd0;
  localparam logic [1:0] DIR_POS_ROW = 2'd1;
  localparam logic [1:0] DIR_NEG_COL = 2'd2;
  localparam logic [1:0] DIR_NEG_ROW = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd65;

  typedef struct packed {
    logic               func;
    logic [RAND_W-1:0]  rand_value;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] start_row;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] wall_col;
    logic [COORD_W-1:0] wall_row;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               finished;
  } res_t;

  // One entry of the path stack.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } cell_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LOOK,
    ST_SETTLE,
    ST_PICK,
    ST_POP,
    ST_OUT
  } state_t;

endpackage

// ===== sv/rdmc_map.sv =====
// Discovered map: one bit per cell, one write port and one registered read port.
module rdmc_map #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: the data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rdmc_stack.sv =====
// Path stack storage: pushed cells are written at the stack pointer and popped
// cells are read back in the cycle after the address is presented.
module rdmc_stack #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  rdmc_pkg::cell_t wdata,
  input  logic [AW-1:0]   raddr,
  output rdmc_pkg::cell_t rdata
);

  rdmc_pkg::cell_t mem [DEPTH];

  // Push port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Pop port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/random_dfs_maze_carver.sv =====
// Channel  Signals                         Direction  Item
// cmd      cmd_valid / cmd_ready / cmd     in         rdmc_pkg::cmd_t
// res      res_valid / res_ready / res     out        rdmc_pkg::res_t
// cfg      cfg_we / cfg_wdata              in         maze_size register
//
// A step item runs four map lookups in ST_LOOK, waits in ST_SETTLE for the last read to
// land, picks and updates in ST_PICK, loads the result in ST_OUT and returns to ST_IDLE.
// A backtrack that pops the path stack adds ST_POP for the stack read.
// A restart item clears the map one entry per cycle; an ignored item goes straight to ST_OUT.
// After reset the same sweep clears every map entry in ST_INIT.
// An item is taken while the last result waits; a stalled output holds the next in ST_OUT.
module random_dfs_maze_carver #(
  parameter int MAX_CELLS_SIDE = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  rdmc_pkg::cmd_t                cmd,
  output logic                          res_valid,
  input  logic                          res_ready,
  output rdmc_pkg::res_t                res,
  input  logic                          cfg_we,
  input  logic [rdmc_pkg::SIZE_W-1:0]   cfg_wdata
);

  localparam int MAP_DEPTH = MAX_CELLS_SIDE * MAX_CELLS_SIDE;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int DW        = $clog2(MAP_DEPTH + 1);
  localparam logic [7:0]    SIZE_MAX = 8'(2 * MAX_CELLS_SIDE + 1);
  localparam logic [6:0]    SIDE7    = 7'(MAX_CELLS_SIDE);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAP_DEPTH - 1);
  localparam logic [DW-1:0] STK_FULL = DW'(MAP_DEPTH);

  // Map address of a cell from its halved coordinates.
  function automatic logic [AW-1:0] cell_index(input logic [5:0] hc, input logic [5:0] hr);
    return AW'(int'(hr) * MAX_CELLS_SIDE + int'(hc));
  endfunction

  // Makes a raw start coordinate odd and clamps it into 1..hi.
  function automatic logic [6:0] fix_start(input logic [6:0] v, input logic down,
                                           input logic [6:0] hi);
    logic signed [8:0] t;
    t = $signed({2'b00, v});
    if (!v[0]) begin
      t = down ? t - 9'sd1 : t + 9'sd1;
    end
    if (t > $signed({2'b00, hi})) begin
      t = $signed({2'b00, hi});
    end
    if (t < 9'sd1) begin
      t = 9'sd1;
    end
    return t[6:0];
  endfunction

  // Remainder of an 8-bit value by three, by folding base-4 digits.
  function automatic logic [1:0] mod3(input logic [7:0] r);
    logic [3:0] s;
    logic [2:0] s2;
    logic [1:0] m;
    s  = 4'(r[1:0]) + 4'(r[3:2]) + 4'(r[5:4]) + 4'(r[7:6]);
    s2 = 3'(s[3:2]) + 3'(s[1:0]);
    case (s2)
      3'd0, 3'd3, 3'd6: m = 2'd0;
      3'd1, 3'd4:       m = 2'd1;
      3'd2, 3'd5:       m = 2'd2;
      default:          m = 2'd0;
    endcase
    return m;
  endfunction

  rdmc_pkg::state_t state, state_next;

  logic [rdmc_pkg::SIZE_W-1:0]  maze_size;
  logic [6:0]                   cur_col, cur_row;
  logic [DW-1:0]                depth;
  logic [rdmc_pkg::COUNT_W-1:0] count;
  logic                         done;
  logic [AW-1:0]                clr_cnt;
  logic [1:0]                   look_d;
  logic                         look_pend, look_ok;
  logic [1:0]                   look_dir;
  logic [3:0]                   open_mask;
  logic [7:0]                   cmd_rand;
  logic [1:0]                   act_r;
  logic [6:0]                   wall_col_r, wall_row_r;

  logic                         map_we, map_wdata, map_rdata;
  logic [AW-1:0]                map_waddr, map_raddr;
  logic                         stk_we;
  logic [AW-1:0]                stk_waddr, stk_raddr;
  rdmc_pkg::cell_t              stk_wdata, stk_rdata;
  logic                         res_load;

  // Effective grid size, last inner coordinate and cells per side.
  logic [7:0]  size_eff;
  logic [6:0]  hi;
  logic [6:0]  size_m1;
  logic [5:0]  cells;
  logic [11:0] target;

  always_comb begin
    if (maze_size < 7'd3) begin
      size_eff = 8'd3;
    end else if ({1'b0, maze_size} > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = {1'b0, maze_size};
    end
    hi      = 7'(size_eff - 8'd2);
    size_m1 = 7'(size_eff - 8'd1);
    cells   = size_m1[6:1];
    target  = 12'({6'b0, cells} * {6'b0, cells}) - 12'd1;
  end

  // Neighbour under lookup: coordinates, range check and map address.
  logic signed [8:0] nb_col, nb_row;
  logic              nb_ok;
  logic [AW-1:0]     nb_idx;

  always_comb begin
    nb_col = $signed({2'b00, cur_col});
    nb_row = $signed({2'b00, cur_row});
    case (look_d)
      rdmc_pkg::DIR_POS_COL: nb_col = $signed({2'b00, cur_col}) + 9'sd2;
      rdmc_pkg::DIR_POS_ROW: nb_row = $signed({2'b00, cur_row}) + 9'sd2;
      rdmc_pkg::DIR_NEG_COL: nb_col = $signed({2'b00, cur_col}) - 9'sd2;
      rdmc_pkg::DIR_NEG_ROW: nb_row = $signed({2'b00, cur_row}) - 9'sd2;
      default: ;
    endcase
    nb_ok = (nb_col > 9'sd0) && (nb_col <= $signed({2'b00, hi})) &&
            (nb_row > 9'sd0) && (nb_row <= $signed({2'b00, hi})) &&
            ({1'b0, nb_col[6:1]} < SIDE7) && ({1'b0, nb_row[6:1]} < SIDE7);
    nb_idx = cell_index(nb_col[6:1], nb_row[6:1]);
  end

  // The current cell's own map entry.
  logic          cur_in;
  logic [AW-1:0] cur_idx;

  assign cur_in  = ({1'b0, cur_col[6:1]} < SIDE7) && ({1'b0, cur_row[6:1]} < SIDE7);
  assign cur_idx = cell_index(cur_col[6:1], cur_row[6:1]);

  // Choice among the open neighbours and the updated discovered count.
  logic [2:0]    n_open;
  logic [1:0]    sel;
  logic [1:0]    pick_dir;
  logic [2:0]    seen;
  logic          stk_has;
  logic          stk_room;
  logic [DW-1:0] depth_m1;
  logic [11:0]   count_new;

  always_comb begin
    n_open = 3'(open_mask[0]) + 3'(open_mask[1]) + 3'(open_mask[2]) + 3'(open_mask[3]);
    case (n_open)
      3'd2:    sel = {1'b0, cmd_rand[0]};
      3'd3:    sel = mod3(cmd_rand);
      3'd4:    sel = cmd_rand[1:0];
      default: sel = 2'd0;
    endcase
    pick_dir = rdmc_pkg::DIR_POS_COL;
    seen     = 3'd0;
    for (int d = 0; d < 4; d++) begin
      if (open_mask[d]) begin
        if (seen == {1'b0, sel}) begin
          pick_dir = 2'(d);
        end
        seen = seen + 3'd1;
      end
    end
    stk_has  = (depth != '0);
    stk_room = (depth < STK_FULL);
    depth_m1 = depth - DW'(1);
    if (open_mask == 4'd0 && stk_has) begin
      count_new = {1'b0, count};
    end else begin
      count_new = {1'b0, count} + 12'd1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rdmc_pkg::ST_INIT: begin
        if (clr_cnt == CLR_LAST) state_next = rdmc_pkg::ST_IDLE;
      end
      rdmc_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.func == rdmc_pkg::FUNC_RESTART && done) begin
            state_next = rdmc_pkg::ST_CLEAR;
          end else if (cmd.func == rdmc_pkg::FUNC_STEP && !done) begin
            state_next = rdmc_pkg::ST_LOOK;
          end else begin
            state_next = rdmc_pkg::ST_OUT;
          end
        end
      end
      rdmc_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = rdmc_pkg::ST_OUT;
      end
      rdmc_pkg::ST_LOOK: begin
        if (look_d == rdmc_pkg::DIR_NEG_ROW) state_next = rdmc_pkg::ST_SETTLE;
      end
      rdmc_pkg::ST_SETTLE: state_next = rdmc_pkg::ST_PICK;
      rdmc_pkg::ST_PICK: begin
        if (open_mask == 4'd0 && stk_has) begin
          state_next = rdmc_pkg::ST_POP;
        end else begin
          state_next = rdmc_pkg::ST_OUT;
        end
      end
      rdmc_pkg::ST_POP: state_next = rdmc_pkg::ST_OUT;
      rdmc_pkg::ST_OUT: begin
        if (!res_valid || res_ready) state_next = rdmc_pkg::ST_IDLE;
      end
      default: state_next = rdmc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine: handshake and memory port controls.
  always_comb begin
    cmd_ready = 1'b0;
    map_we    = 1'b0;
    map_waddr = clr_cnt;
    map_wdata = 1'b0;
    map_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = depth[AW-1:0];
    stk_wdata = '{col: cur_col, row: cur_row};
    stk_raddr = '0;
    res_load  = 1'b0;
    case (state)
      rdmc_pkg::ST_INIT, rdmc_pkg::ST_CLEAR: begin
        map_we = 1'b1;
      end
      rdmc_pkg::ST_IDLE: cmd_ready = 1'b1;
      rdmc_pkg::ST_LOOK: begin
        map_raddr = nb_ok ? nb_idx : '0;
      end
      rdmc_pkg::ST_PICK: begin
        map_we    = cur_in;
        map_waddr = cur_idx;
        map_wdata = 1'b1;
        if (open_mask != 4'd0) begin
          stk_we = stk_room;
        end else if (stk_has) begin
          stk_raddr = depth_m1[AW-1:0];
        end
      end
      rdmc_pkg::ST_OUT: res_load = !res_valid || res_ready;
      default: ;
    endcase
  end

  // Control state and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdmc_pkg::ST_INIT;
      maze_size <= rdmc_pkg::SIZE_RESET;
      cur_col   <= 7'd1;
      cur_row   <= 7'd1;
      depth     <= '0;
      count     <= '0;
      done      <= 1'b1;
      clr_cnt   <= '0;
      look_d    <= '0;
      look_pend <= 1'b0;
    end else begin
      state     <= state_next;
      look_pend <= (state == rdmc_pkg::ST_LOOK);
      look_ok   <= nb_ok;
      look_dir  <= look_d;
      if (cfg_we) begin
        maze_size <= cfg_wdata;
      end
      // Collect one neighbour's verdict in the cycle after its lookup.
      if (look_pend) begin
        open_mask[look_dir] <= look_ok & ~map_rdata;
      end
      case (state)
        rdmc_pkg::ST_INIT, rdmc_pkg::ST_CLEAR: clr_cnt <= clr_cnt + AW'(1);
        rdmc_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            cmd_rand   <= cmd.rand_value;
            wall_col_r <= '0;
            wall_row_r <= '0;
            open_mask  <= '0;
            look_d     <= '0;
            clr_cnt    <= '0;
            act_r      <= rdmc_pkg::ACT_IGNORE;
            if (cmd.func == rdmc_pkg::FUNC_RESTART && done) begin
              cur_col <= fix_start(cmd.start_col, cmd.rand_value[0], hi);
              cur_row <= fix_start(cmd.start_row, cmd.rand_value[0], hi);
              depth   <= '0;
              count   <= '0;
              done    <= 1'b0;
              act_r   <= rdmc_pkg::ACT_RESTART;
            end
          end
        end
        rdmc_pkg::ST_LOOK: look_d <= look_d + 2'd1;
        rdmc_pkg::ST_PICK: begin
          done  <= (count_new >= target);
          count <= count_new[11] ? {rdmc_pkg::COUNT_W{1'b1}} : count_new[10:0];
          if (open_mask == 4'd0) begin
            act_r <= rdmc_pkg::ACT_BACK;
            if (stk_has) depth <= depth_m1;
          end else begin
            act_r <= rdmc_pkg::ACT_CARVE;
            if (stk_room) depth <= depth + DW'(1);
            case (pick_dir)
              rdmc_pkg::DIR_POS_COL: begin
                wall_col_r <= cur_col + 7'd1;
                wall_row_r <= cur_row;
                cur_col    <= cur_col + 7'd2;
              end
              rdmc_pkg::DIR_POS_ROW: begin
                wall_col_r <= cur_col;
                wall_row_r <= cur_row + 7'd1;
                cur_row    <= cur_row + 7'd2;
              end
              rdmc_pkg::DIR_NEG_COL: begin
                wall_col_r <= cur_col - 7'd1;
                wall_row_r <= cur_row;
                cur_col    <= cur_col - 7'd2;
              end
              rdmc_pkg::DIR_NEG_ROW: begin
                wall_col_r <= cur_col;
                wall_row_r <= cur_row - 7'd1;
                cur_row    <= cur_row - 7'd2;
              end
              default: ;
            endcase
          end
        end
        rdmc_pkg::ST_POP: begin
          cur_col <= stk_rdata.col;
          cur_row <= stk_rdata.row;
        end
        default: ;
      endcase
    end
  end

  // Output register: holds one result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= '{action:   act_r,
               wall_col: wall_col_r,
               wall_row: wall_row_r,
               cell_col: cur_col,
               cell_row: cur_row,
               finished: done};
    end
  end

  rdmc_map #(
    .DEPTH(MAP_DEPTH),
    .AW   (AW)
  ) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .raddr(map_raddr),
    .rdata(map_rdata)
  );

  rdmc_stack #(
    .DEPTH(MAP_DEPTH),
    .AW   (AW)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

endmodule
